// ===== design/ids_pkg.sv =====
// shared constants and the cordic arctangent table for the intercept direction solver
// no dependencies
`default_nettype none

package ids_pkg;

  // configuration register indexes
  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_STEPS = 1'b1;

  // register reset values and bisection step limit
  localparam logic [30:0] ACCEL_RESET = 31'd65536;
  localparam logic [5:0]  STEPS_RESET = 6'd16;
  localparam logic [5:0]  STEPS_MAX   = 6'd32;

  // default parameter values
  localparam int MAX_DOUBLINGS_DEF    = 16;
  localparam int ANGLE_ITERATIONS_DEF = 16;

  // time cap and start limit (raw q16.16)
  localparam logic [31:0] TIME_CAP  = 32'hFFFF_FFFF;
  localparam logic [49:0] START_LIM = 50'h0_0000_FFFF_0000 - 50'd1;

  // cordic table depth
  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IW    = 5;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic [31:0] turn_atan(input logic [ATAN_IW-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/intercept_direction_solver_unit.sv =====
// intercept direction solver: sequencer around one shared 32x32 multiplier,
// a bit-serial square root and divider, and an iterative cordic; uses ids_pkg
`default_nettype none

//  channel  | signals                              | contents
//  s_axis   | s_axis_tvalid/tready/tdata[127:0]    | relative position and velocity
//  m_axis   | m_axis_tvalid/tready/tdata[55:0]     | heading, time, saturation flag
//  cfg      | cfg_we/cfg_index/cfg_data[30:0]      | accel, bisection_steps
//
// one transaction runs E quartic evaluations, E being doublings + 1 + bisection
// steps; each evaluation is 19 partial products through the shared multiplier.
// rst is synchronous; s_axis_tready is high only while the sequencer is idle,
// and a finished result waits in the output register while a new one is taken.

module intercept_direction_solver_unit
  import ids_pkg::*;
#(
  parameter int MAX_DOUBLINGS    = MAX_DOUBLINGS_DEF,
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // direction_angle[15:0], intercept_time[47:16], bound_saturated[48], zero fill
  output logic [55:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int CW = $clog2(MAX_DOUBLINGS + 1);
  localparam int NA = (ANGLE_ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH : ANGLE_ITERATIONS;
  localparam logic [CW-1:0] DBL_LIM = CW'(MAX_DOUBLINGS);
  localparam logic [ATAN_IW-1:0] CORD_LAST = ATAN_IW'(NA - 1);
  localparam logic signed [63:0] NORM_HI = 64'sd1 <<< 40;
  localparam logic signed [63:0] NORM_LO = -(64'sd1 <<< 40);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M_PX = 5'd1;
  localparam logic [4:0] S_M_PY = 5'd2;
  localparam logic [4:0] S_M_VX = 5'd3;
  localparam logic [4:0] S_M_VY = 5'd4;
  localparam logic [4:0] S_M_D1 = 5'd5;
  localparam logic [4:0] S_M_D2 = 5'd6;
  localparam logic [4:0] S_M_A  = 5'd7;
  localparam logic [4:0] S_SQRT = 5'd8;
  localparam logic [4:0] S_DIV  = 5'd9;
  localparam logic [4:0] S_BMUL = 5'd10;
  localparam logic [4:0] S_BADD = 5'd11;
  localparam logic [4:0] S_Q0   = 5'd12;
  localparam logic [4:0] S_Q1   = 5'd13;
  localparam logic [4:0] S_Q2   = 5'd14;
  localparam logic [4:0] S_Q3   = 5'd15;
  localparam logic [4:0] S_Q4   = 5'd16;
  localparam logic [4:0] S_Q5   = 5'd17;
  localparam logic [4:0] S_Q6   = 5'd18;
  localparam logic [4:0] S_AIMX = 5'd19;
  localparam logic [4:0] S_AIMY = 5'd20;
  localparam logic [4:0] S_AIMZ = 5'd21;
  localparam logic [4:0] S_NORM = 5'd22;
  localparam logic [4:0] S_CORD = 5'd23;
  localparam logic [4:0] S_DONE = 5'd24;

  logic [4:0] state;

  // configuration registers
  logic [30:0] accel;
  logic [5:0]  bis_steps;

  // latched operands
  logic [31:0] mpx, mpy, mvx, mvy;
  logic        npx, npy, nvx, nvy;
  logic signed [31:0] px, py;
  logic [30:0] a_eff;
  logic [5:0]  steps;
  logic [63:0] p2, v2, m1, pvm, a2, t2;
  logic        pvn;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // square root and divider
  logic [63:0] sq_n, sq_r;
  logic [4:0]  sq_k;
  logic [49:0] dv_q;
  logic [31:0] dv_rem;
  logic [5:0]  dv_k;

  // wide multiply engine
  logic [127:0] bm_a, bm_b;
  logic [1:0]   bm_na, bm_nb, bm_i, bm_j;
  logic [191:0] bm_acc;
  logic [4:0]   bm_ret;

  // quartic evaluation
  logic [191:0] qpos, qneg;
  logic [31:0]  q_t, lo, hi;
  logic [CW-1:0] dbl_cnt;
  logic          bisect, flag;
  logic [5:0]    bis_k;

  // aim point and cordic
  logic signed [63:0] cx, cy;
  logic [31:0]        ang;
  logic [ATAN_IW-1:0] cord_i;

  // output register
  logic [15:0] out_dir;
  logic [31:0] out_time;
  logic        out_flag;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {7'd0, out_flag, out_time, out_dir};

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_M_PX: begin mul_a = mpx; mul_b = mpx; end
      S_M_PY: begin mul_a = mpy; mul_b = mpy; end
      S_M_VX: begin mul_a = mvx; mul_b = mvx; end
      S_M_VY: begin mul_a = mvy; mul_b = mvy; end
      S_M_D1: begin mul_a = mpx; mul_b = mvx; end
      S_M_D2: begin mul_a = mpy; mul_b = mvy; end
      S_M_A:  begin mul_a = {1'b0, a_eff}; mul_b = {1'b0, a_eff}; end
      S_BMUL: begin mul_a = bm_a[32*bm_i +: 32]; mul_b = bm_b[32*bm_j +: 32]; end
      S_AIMX: begin mul_a = mvx; mul_b = lo; end
      S_AIMY: begin mul_a = mvy; mul_b = lo; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // combinational helpers for the sequencer
  logic [63:0]  sq_bit, sq_sum;
  logic [32:0]  dv_trial;
  logic [191:0] bm_add;
  logic [32:0]  mid_sum;
  logic [31:0]  hi_dbl;
  logic         q_gt, q_ge;
  logic [63:0]  m1_dot;
  logic [63:0]  sf_mag;
  logic signed [63:0] sf_val;
  logic signed [63:0] cxs, cys;
  logic [31:0]  lo_b, hi_b;

  always_comb begin
    sq_bit   = 64'd1 << (6'd62 - {sq_k, 1'b0});
    sq_sum   = sq_r + sq_bit;
    dv_trial = {dv_rem, dv_q[49]} - {2'b0, a_eff};
    bm_add   = bm_acc + (({128'd0, mul_p}) << {({1'b0, bm_i} + {1'b0, bm_j}), 5'd0});
    q_gt     = qpos > qneg;
    q_ge     = qpos >= qneg;
    hi_dbl   = hi[31] ? TIME_CAP : {hi[30:0], 1'b0};
    lo_b     = q_ge ? q_t : lo;
    hi_b     = q_ge ? hi : q_t;
    mid_sum  = {1'b0, lo_b} + {1'b0, hi_b};
    m1_dot   = m1;
    // floor of velocity times time, scaled back to q16.16
    sf_mag   = (state == S_AIMY ? nvx : nvy) ? ((mul_p + 64'd65535) >> 16)
                                               : (mul_p >> 16);
    sf_val   = (state == S_AIMY ? nvx : nvy) ? -$signed(sf_mag) : $signed(sf_mag);
    cxs      = cx >>> cord_i;
    cys      = cy >>> cord_i;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      accel         <= ACCEL_RESET;
      bis_steps     <= STEPS_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACCEL: accel     <= cfg_data;
          REG_STEPS: bis_steps <= cfg_data[5:0];
          default:   accel     <= accel;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            px    <= s_axis_tdata[31:0];
            py    <= s_axis_tdata[63:32];
            npx   <= s_axis_tdata[31];
            npy   <= s_axis_tdata[63];
            nvx   <= s_axis_tdata[95];
            nvy   <= s_axis_tdata[127];
            mpx   <= s_axis_tdata[31]  ? -s_axis_tdata[31:0]   : s_axis_tdata[31:0];
            mpy   <= s_axis_tdata[63]  ? -s_axis_tdata[63:32]  : s_axis_tdata[63:32];
            mvx   <= s_axis_tdata[95]  ? -s_axis_tdata[95:64]  : s_axis_tdata[95:64];
            mvy   <= s_axis_tdata[127] ? -s_axis_tdata[127:96] : s_axis_tdata[127:96];
            a_eff <= (accel == '0) ? 31'd1 : accel;
            steps <= (bis_steps > STEPS_MAX) ? STEPS_MAX : bis_steps;
            state <= S_M_PX;
          end
        end
        // magnitudes and dot product
        S_M_PX: state <= S_M_PY;
        S_M_PY: begin p2 <= mul_p; state <= S_M_VX; end
        S_M_VX: begin p2 <= p2 + mul_p; state <= S_M_VY; end
        S_M_VY: begin v2 <= mul_p; state <= S_M_D1; end
        S_M_D1: begin v2 <= v2 + mul_p; state <= S_M_D2; end
        S_M_D2: begin m1 <= mul_p; state <= S_M_A; end
        S_M_A: begin
          if ((npx ^ nvx) == (npy ^ nvy)) begin
            pvm <= m1_dot + mul_p;
            pvn <= (npx ^ nvx) && ((m1_dot + mul_p) != 64'd0);
          end else if (m1_dot >= mul_p) begin
            pvm <= m1_dot - mul_p;
            pvn <= (npx ^ nvx) && (m1_dot != mul_p);
          end else begin
            pvm <= mul_p - m1_dot;
            pvn <= npy ^ nvy;
          end
          sq_n  <= v2;
          sq_r  <= '0;
          sq_k  <= '0;
          state <= S_SQRT;
        end
        // bit-serial integer square root of |v|^2
        S_SQRT: begin
          if (sq_k == 5'd0) a2 <= mul_p;
          if (sq_n >= sq_sum) begin
            sq_n <= sq_n - sq_sum;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_k <= sq_k + 5'd1;
          if (sq_k == 5'd31) begin
            dv_rem <= '0;
            dv_k   <= '0;
            state  <= S_DIV;
          end
        end
        // restoring divide of |v|*2^18 by accel
        S_DIV: begin
          if (dv_k == 6'd0) begin
            dv_q   <= {sq_r[31:0], 18'd0};
            dv_k   <= 6'd1;
          end else begin
            if (!dv_trial[32]) begin
              dv_rem <= dv_trial[31:0];
              dv_q   <= {dv_q[48:0], 1'b1};
            end else begin
              dv_rem <= {dv_rem[30:0], dv_q[49]};
              dv_q   <= {dv_q[48:0], 1'b0};
            end
            dv_k <= dv_k + 6'd1;
            if (dv_k == 6'd50) begin
              state <= S_AIMZ;
            end
          end
        end
        // wide multiply: one partial product per pass through S_BMUL and S_BADD
        S_BMUL: state <= S_BADD;
        S_BADD: begin
          bm_acc <= bm_add;
          if (bm_j == bm_nb) begin
            bm_j <= '0;
            if (bm_i == bm_na) begin
              state <= bm_ret;
            end else begin
              bm_i  <= bm_i + 2'd1;
              state <= S_BMUL;
            end
          end else begin
            bm_j  <= bm_j + 2'd1;
            state <= S_BMUL;
          end
        end
        // quartic sign at q_t
        S_Q0: begin
          bm_a <= {96'd0, q_t}; bm_b <= {96'd0, q_t};
          bm_na <= 2'd0; bm_nb <= 2'd0; bm_i <= '0; bm_j <= '0;
          bm_acc <= '0; bm_ret <= S_Q1; state <= S_BMUL;
        end
        S_Q1: begin
          t2 <= bm_acc[63:0];
          bm_a <= {64'd0, bm_acc[63:0]}; bm_b <= {64'd0, bm_acc[63:0]};
          bm_na <= 2'd1; bm_nb <= 2'd1; bm_i <= '0; bm_j <= '0;
          bm_acc <= '0; bm_ret <= S_Q2; state <= S_BMUL;
        end
        S_Q2: begin
          bm_a <= {64'd0, a2}; bm_b <= bm_acc[127:0];
          bm_na <= 2'd1; bm_nb <= 2'd3; bm_i <= '0; bm_j <= '0;
          bm_acc <= '0; bm_ret <= S_Q3; state <= S_BMUL;
        end
        S_Q3: begin
          qneg <= bm_acc;
          bm_a <= {64'd0, v2}; bm_b <= {64'd0, t2};
          bm_na <= 2'd1; bm_nb <= 2'd1; bm_i <= '0; bm_j <= '0;
          bm_acc <= '0; bm_ret <= S_Q4; state <= S_BMUL;
        end
        S_Q4: begin
          qpos <= (({128'd0, p2}) << 66) + (bm_acc << 34);
          bm_a <= {64'd0, pvm}; bm_b <= {96'd0, q_t};
          bm_na <= 2'd1; bm_nb <= 2'd0; bm_i <= '0; bm_j <= '0;
          bm_acc <= '0; bm_ret <= S_Q5; state <= S_BMUL;
        end
        S_Q5: begin
          if (pvn) qneg <= qneg + (bm_acc << 51);
          else     qpos <= qpos + (bm_acc << 51);
          state <= S_Q6;
        end
        S_Q6: begin
          if (!bisect) begin
            // upper bound search
            if (q_gt && (dbl_cnt < DBL_LIM)) begin
              hi      <= hi_dbl;
              q_t     <= hi_dbl;
              dbl_cnt <= dbl_cnt + CW'(1);
              state   <= S_Q0;
            end else begin
              flag   <= q_gt;
              bisect <= 1'b1;
              bis_k  <= '0;
              q_t    <= hi >> 1;
              state  <= (steps == 6'd0) ? S_AIMX : S_Q0;
            end
          end else begin
            // bisection step
            lo    <= lo_b;
            hi    <= hi_b;
            q_t   <= mid_sum[32:1];
            bis_k <= bis_k + 6'd1;
            state <= (bis_k + 6'd1 == steps) ? S_AIMX : S_Q0;
          end
        end
        // start bound from the quotient
        S_AIMZ: begin
          hi      <= (dv_q > START_LIM) ? TIME_CAP : dv_q[31:0] + 32'd65536;
          q_t     <= (dv_q > START_LIM) ? TIME_CAP : dv_q[31:0] + 32'd65536;
          lo      <= '0;
          dbl_cnt <= '0;
          bisect  <= 1'b0;
          state   <= S_Q0;
        end
        // aim point p + floor(v*t)
        S_AIMX: state <= S_AIMY;
        S_AIMY: begin
          cx    <= 64'(px) + sf_val;
          state <= S_NORM;
          cord_i <= '0;
          ang   <= '0;
          cy    <= '0;
          qpos  <= '0;
        end
        S_NORM: begin
          if (qpos == '0) begin
            // first cycle here: finish the y coordinate
            cy   <= 64'(py) + sf_val;
            qpos <= 192'd1;
          end else if (cx == 64'sd0 && cy == 64'sd0) begin
            ang   <= '0;
            state <= S_DONE;
          end else if (cx < NORM_HI && cx > NORM_LO && cy < NORM_HI && cy > NORM_LO) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            if (cx < 64'sd0) begin
              cx  <= -cx;
              cy  <= -cy;
              ang <= 32'h8000_0000;
            end
            state <= S_CORD;
          end
        end
        // cordic vectoring, one rotation per cycle
        S_CORD: begin
          if (cy > 64'sd0) begin
            cx  <= cx + cys;
            cy  <= cy - cxs;
            ang <= ang + turn_atan(cord_i);
          end else begin
            cx  <= cx - cys;
            cy  <= cy + cxs;
            ang <= ang - turn_atan(cord_i);
          end
          cord_i <= cord_i + ATAN_IW'(1);
          if (cord_i == CORD_LAST) state <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_dir       <= 16'((ang + 32'h0000_8000) >> 16);
            out_time      <= lo;
            out_flag      <= flag;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/ids_checker.sv =====
// intercept solver checker: watches the config port and both streams, predicts each result
// from the relative position and velocity, and compares fields; uses ids_pkg
`timescale 1ns / 1ps

module ids_checker
  import ids_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  // rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // direction_angle[15:0], intercept_time[47:16], bound_saturated[48], zero fill
  input  wire logic [55:0]  m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [30:0]  cfg_data,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [15:0] angle;
    logic [31:0] itime;
    logic        sat;
  } intercept_t;

  intercept_t  intercepts_due[$];
  logic [30:0] accel_q;
  logic [5:0]  steps_q;

  function automatic logic [63:0] mag64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // sign of the quartic scaled by 2^98, kept exact in 256 bits
  function automatic int quartic_cmp(input logic [63:0] p2, input logic [63:0] pvm,
                                     input bit pvn, input logic [63:0] v2,
                                     input logic [63:0] a, input logic [63:0] t);
    logic [255:0] pos, neg, tt, term;
    tt   = 256'(t) * 256'(t);
    pos  = 256'(p2) << 66;
    pos  = pos + ((256'(v2) * tt) << 34);
    term = (256'(pvm) * 256'(t)) << 51;
    if (pvn) begin
      neg = term;
    end else begin
      pos = pos + term;
      neg = 0;
    end
    neg = neg + 256'(a) * 256'(a) * tt * tt;
    if (pos > neg) return 1;
    if (pos == neg) return 0;
    return -1;
  endfunction

  // velocity times time, floored to q16.16
  function automatic longint vel_times(input longint vel, input logic [63:0] t);
    logic [63:0] m;
    m = mag64(vel) * t;
    if (vel < 0) return -longint'((m + 64'd65535) >> 16);
    return longint'(m >> 16);
  endfunction

  // cordic vectoring, 2^32 units per turn
  function automatic logic [31:0] aim_heading(input longint x, input longint y);
    logic [31:0] ang;
    longint      xs, ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    while (mag64(x) < (64'd1 << 40) && mag64(y) < (64'd1 << 40)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < ANGLE_ITERATIONS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; ang = ang + turn_atan(ATAN_IW'(i));
      end else begin
        x = x - ys; y = y + xs; ang = ang - turn_atan(ATAN_IW'(i));
      end
    end
    return ang;
  endfunction

  function automatic intercept_t solve_intercept(input logic [127:0] d);
    longint      px, py, vx, vy;
    logic [63:0] a, p2, v2, m1, m2, pvm, lo, hi, start, mid;
    logic [31:0] ang;
    bit          n1, n2, pvn;
    int          cnt, nsteps;
    intercept_t  r;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    vx = longint'($signed(d[95:64]));
    vy = longint'($signed(d[127:96]));
    a  = (accel_q == 0) ? 64'd1 : 64'(accel_q);
    p2 = mag64(px) * mag64(px) + mag64(py) * mag64(py);
    v2 = mag64(vx) * mag64(vx) + mag64(vy) * mag64(vy);
    // p.v in sign and magnitude
    m1 = mag64(px) * mag64(vx);
    m2 = mag64(py) * mag64(vy);
    n1 = (px < 0) != (vx < 0);
    n2 = (py < 0) != (vy < 0);
    if (n1 == n2) begin
      pvm = m1 + m2; pvn = n1;
    end else if (m1 >= m2) begin
      pvm = m1 - m2; pvn = n1;
    end else begin
      pvm = m2 - m1; pvn = n2;
    end
    if (pvm == 0) pvn = 0;
    // upper bound search
    start = (isqrt(v2) << 18) / a;
    hi = (start > 64'(TIME_CAP) - 64'd65536) ? 64'(TIME_CAP) : start + 64'd65536;
    cnt = 0;
    while (cnt < MAX_DOUBLINGS_DEF && quartic_cmp(p2, pvm, pvn, v2, a, hi) > 0) begin
      hi = (hi > 64'(TIME_CAP) / 2) ? 64'(TIME_CAP) : hi * 2;
      cnt++;
    end
    r.sat = quartic_cmp(p2, pvm, pvn, v2, a, hi) > 0;
    // bisection
    lo = 0;
    nsteps = (steps_q > STEPS_MAX) ? int'(STEPS_MAX) : int'(steps_q);
    for (int k = 0; k < nsteps; k++) begin
      mid = (lo + hi) >> 1;
      if (quartic_cmp(p2, pvm, pvn, v2, a, mid) >= 0) lo = mid;
      else hi = mid;
    end
    ang = aim_heading(px + vel_times(vx, lo), py + vel_times(vy, lo));
    ang = ang + 32'h8000;
    r.angle = ang[31:16];
    r.itime = lo[31:0];
    return r;
  endfunction

  assign outstanding = intercepts_due.size();

  // config shadow, input prediction, output compare
  always_ff @(posedge clk) begin
    intercept_t e;
    int         errs;
    errs = 0;
    if (rst) begin
      accel_q    <= ACCEL_RESET;
      steps_q    <= STEPS_RESET;
      mismatches <= 0;
      intercepts_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ACCEL) accel_q <= cfg_data;
        else steps_q <= cfg_data[5:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        intercepts_due.push_back(solve_intercept(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (intercepts_due.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_axis_tdata);
          errs++;
        end else begin
          e = intercepts_due.pop_front();
          if (m_axis_tdata[15:0] !== e.angle) begin
            $error("direction_angle expected %h actual %h", e.angle, m_axis_tdata[15:0]);
            errs++;
          end
          if (m_axis_tdata[47:16] !== e.itime) begin
            $error("intercept_time expected %h actual %h", e.itime, m_axis_tdata[47:16]);
            errs++;
          end
          if (m_axis_tdata[48] !== e.sat) begin
            $error("bound_saturated expected %b actual %b", e.sat, m_axis_tdata[48]);
            errs++;
          end
        end
      end
      mismatches <= mismatches + errs;
    end
  end

endmodule

// ===== bench/tb_intercept_direction_solver_unit.sv =====
// testbench top for intercept_direction_solver_unit: clock, reset, config phases,
// directed and random stimulus, result sink; relies on ids_checker and ids_pkg
`timescale 1ns / 1ps

module tb_intercept_direction_solver_unit
  import ids_pkg::*;
;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [55:0]  m_axis_tdata;
  logic         cfg_we, cfg_index;
  logic [30:0]  cfg_data;
  int           mismatches, outstanding;
  int           results_taken;
  bit           no_idle;

  intercept_direction_solver_unit u_dut (.*);

  ids_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000 + 32'($urandom_range(0, 1)) * 32'h7FFF_FFFF;
      1:       return 32'($urandom_range(0, 1 << 20)) * ($urandom_range(0, 1) ? 1 : -1);
      2:       return 32'($urandom_range(0, 1 << 24)) * ($urandom_range(0, 1) ? 1 : -1);
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] vx, input logic [31:0] vy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata  = {vy, vx, py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  // result sink with one long hold-off to back the block up
  initial begin
    int gap;
    m_axis_tready = 0;
    results_taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (results_taken == 40) gap = 6000;
      if (gap > 0) begin
        m_axis_tready = 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    logic [30:0] accel_set[5];
    logic [5:0]  steps_set[5];
    int          wait_cycles;
    rst = 1;
    no_idle = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    cfg_we = 0;
    cfg_index = REG_ACCEL;
    cfg_data = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero aim, half turn, field extremes, stationary and fleeing targets
    send_item(0, 0, 0, 0);
    send_item(32'hFFFF_0000, 0, 0, 0);
    send_item(32'h0001_0000, 0, 0, 0);
    send_item(0, 32'h0001_0000, 0, 0);
    send_item(0, 32'hFFFF_0000, 0, 0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h0010_0000, 0, 32'h0002_0000, 0);
    send_item(32'h0010_0000, 0, 32'hFFFE_0000, 0);
    send_item(0, 0, 32'h0003_0000, 32'h0004_0000);
    send_item(32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
    send_item(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // register settings per phase, extremes included
    accel_set = '{ACCEL_RESET, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd0};
    steps_set = '{STEPS_RESET, 6'd0, STEPS_MAX, 6'd63, 6'd0};
    accel_set[4] = 31'($urandom_range(1, 1 << 22));
    steps_set[4] = 6'($urandom_range(1, 32));
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_ACCEL, accel_set[ph]);
      write_reg(REG_STEPS, 31'(steps_set[ph]));
      no_idle = (ph == 2);
      for (int n = 0; n < 208; n++)
        send_item(pick_field(), pick_field(), pick_field(), pick_field());
      // sender pauses until all results are back
      drain();
    end

    no_idle = 0;
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (200) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ids_pkg.sv
design/intercept_direction_solver_unit.sv
bench/ids_checker.sv
bench/tb_intercept_direction_solver_unit.sv
